// ===== src/vt4_pkg.sv =====
// vt4_pkg: shared constants and types for the vertex transform block
// no dependencies
package vt4_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = 32 + FRAC_BITS;  // width of the shifted dividend
  localparam int DIV_STEPS = NUM_W;           // one quotient bit per stage
  localparam int NUM_REGS  = 8;

  localparam logic [63:0] ONE_FX = 64'(1) << FRAC_BITS;

  typedef enum logic {
    CMD_FULL  = 1'b0,
    CMD_POINT = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ROW0_XY = 3'd0,
    REG_ROW0_ZW = 3'd1,
    REG_ROW1_XY = 3'd2,
    REG_ROW1_ZW = 3'd3,
    REG_ROW2_XY = 3'd4,
    REG_ROW2_ZW = 3'd5,
    REG_ROW3_XY = 3'd6,
    REG_ROW3_ZW = 3'd7
  } reg_idx_t;

  // side data that travels alongside the divider lanes
  typedef struct packed {
    logic              div_en;
    logic              wz;
    logic              ovf;
    logic [2:0]        neg;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } meta_t;

endpackage

// ===== src/vertex_transform_4x4.sv =====
// vertex_transform_4x4: row vector times 4x4 Q16.16 matrix with perspective divide
// depends on vt4_pkg

// Fully pipelined: one word enters per clock unless the output stalls, and results
// leave in order. The pipe's length comes from the restoring divider, which resolves
// one quotient bit per stage for each of x, y and z in parallel lanes; the front end
// is one stage of sixteen 32x32 multiplies, two stages of summing and saturation,
// and one stage of divide setup. The whole pipe advances together whenever the
// output register is empty or being taken, so a downstream stall freezes every stage
// and nothing is dropped or repeated. Matrix registers must be written through the
// cfg port only while no word is in flight; the block itself does not enforce this.
module vertex_transform_4x4 (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [31:0] in_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic               w_zero,
  output logic               overflow
);

  localparam int NW = vt4_pkg::NUM_W;
  localparam int DS = vt4_pkg::DIV_STEPS;
  localparam int F  = vt4_pkg::FRAC_BITS;

  // matrix registers, reset to identity
  logic [63:0] mreg [vt4_pkg::NUM_REGS];
  logic signed [31:0] mat [4][4];  // [row][col]
  logic adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mreg[vt4_pkg::REG_ROW0_XY] <= vt4_pkg::ONE_FX;
      mreg[vt4_pkg::REG_ROW0_ZW] <= '0;
      mreg[vt4_pkg::REG_ROW1_XY] <= vt4_pkg::ONE_FX << 32;
      mreg[vt4_pkg::REG_ROW1_ZW] <= '0;
      mreg[vt4_pkg::REG_ROW2_XY] <= '0;
      mreg[vt4_pkg::REG_ROW2_ZW] <= vt4_pkg::ONE_FX;
      mreg[vt4_pkg::REG_ROW3_XY] <= '0;
      mreg[vt4_pkg::REG_ROW3_ZW] <= vt4_pkg::ONE_FX << 32;
    end else if (cfg_we) begin
      mreg[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = mreg[2*r][31:0];
      mat[r][1] = mreg[2*r][63:32];
      mat[r][2] = mreg[2*r+1][31:0];
      mat[r][3] = mreg[2*r+1][63:32];
    end
  end

  // stage 1: sixteen exact products
  logic signed [31:0] vin [4];
  logic               v1, cmd1;
  logic signed [63:0] prod [4][4];  // [col][row]

  always_comb begin
    vin[0] = in_x;
    vin[1] = in_y;
    vin[2] = in_z;
    vin[3] = (command == vt4_pkg::CMD_POINT) ? 32'(vt4_pkg::ONE_FX) : in_w;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1 <= command;
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          prod[c][r] <= vin[r] * mat[r][c];
    end
  end

  // stage 2: pair sums
  logic               v2, cmd2;
  logic signed [64:0] psum [4][2];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2 <= cmd1;
      for (int c = 0; c < 4; c++) begin
        psum[c][0] <= 65'(prod[c][0]) + 65'(prod[c][1]);
        psum[c][1] <= 65'(prod[c][2]) + 65'(prod[c][3]);
      end
    end
  end

  // stage 3: full sum, floor shift, saturate
  logic signed [65:0] tot [4];
  logic signed [65:0] shv [4];
  logic signed [31:0] res3_next [4];
  logic               ovf3_next;
  logic               v3, cmd3, ovf3;
  logic signed [31:0] res3 [4];

  always_comb begin
    ovf3_next = 1'b0;
    for (int c = 0; c < 4; c++) begin
      tot[c] = 66'(psum[c][0]) + 66'(psum[c][1]);
      shv[c] = tot[c] >>> F;
      if (shv[c] > 66'sd2147483647) begin
        res3_next[c] = 32'sh7fffffff;
        ovf3_next    = 1'b1;
      end else if (shv[c] < -66'sd2147483648) begin
        res3_next[c] = 32'sh80000000;
        ovf3_next    = 1'b1;
      end else begin
        res3_next[c] = shv[c][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd3 <= cmd2;
      ovf3 <= ovf3_next;
      for (int c = 0; c < 4; c++) res3[c] <= res3_next[c];
    end
  end

  // stage 4 onward: divide setup then one restoring step per stage
  vt4_pkg::meta_t meta [DS+1];
  logic           dv   [DS+1];
  logic [31:0]    dden [DS+1];
  logic [31:0]    rem  [DS+1][3];
  logic [NW-1:0]  quo  [DS+1][3];
  vt4_pkg::meta_t meta4_next;
  logic [31:0]    mag  [3];

  always_comb begin
    meta4_next.wz     = (cmd3 == vt4_pkg::CMD_POINT) && (res3[3] == '0);
    meta4_next.div_en = (cmd3 == vt4_pkg::CMD_POINT) && (res3[3] != '0);
    meta4_next.ovf    = ovf3;
    meta4_next.x      = res3[0];
    meta4_next.y      = res3[1];
    meta4_next.z      = res3[2];
    meta4_next.w      = res3[3];
    for (int c = 0; c < 3; c++) begin
      meta4_next.neg[c] = res3[c][31] ^ res3[3][31];
      mag[c] = res3[c][31] ? 32'(-res3[c]) : 32'(res3[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta[0] <= meta4_next;
      dden[0] <= res3[3][31] ? 32'(-res3[3]) : 32'(res3[3]);
      for (int c = 0; c < 3; c++) begin
        rem[0][c] <= '0;
        quo[0][c] <= {mag[c], {F{1'b0}}};
      end
    end
  end

  for (genvar s = 0; s < DS; s++) begin : g_div
    logic [32:0] trial [3];
    logic [31:0] rem_next [3];
    logic [NW-1:0] quo_next [3];

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        trial[c] = {rem[s][c], quo[s][c][NW-1]};
        if (trial[c] >= {1'b0, dden[s]}) begin
          rem_next[c] = 32'(trial[c] - {1'b0, dden[s]});
          quo_next[c] = {quo[s][c][NW-2:0], 1'b1};
        end else begin
          rem_next[c] = trial[c][31:0];
          quo_next[c] = {quo[s][c][NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv[s+1] <= 1'b0;
      else if (adv) dv[s+1] <= dv[s];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        meta[s+1] <= meta[s];
        dden[s+1] <= dden[s];
        for (int c = 0; c < 3; c++) begin
          rem[s+1][c] <= rem_next[c];
          quo[s+1][c] <= quo_next[c];
        end
      end
    end
  end

  // final: sign and saturate quotients, select against undivided values
  vt4_pkg::meta_t mf;
  logic signed [31:0] qv  [3];
  logic               qovf [3];
  logic signed [31:0] undiv [3];
  logic signed [31:0] fin [3];
  logic               ovf_next;

  assign mf = meta[DS];

  always_comb begin
    undiv[0] = mf.x;
    undiv[1] = mf.y;
    undiv[2] = mf.z;
    ovf_next = mf.ovf;
    for (int c = 0; c < 3; c++) begin
      qovf[c] = 1'b0;
      if (mf.neg[c]) begin
        if (quo[DS][c] > NW'(64'h80000000)) begin
          qv[c]   = 32'sh80000000;
          qovf[c] = 1'b1;
        end else begin
          qv[c] = 32'(-quo[DS][c][31:0]);
        end
      end else begin
        if (quo[DS][c] > NW'(64'h7fffffff)) begin
          qv[c]   = 32'sh7fffffff;
          qovf[c] = 1'b1;
        end else begin
          qv[c] = quo[DS][c][31:0];
        end
      end
      fin[c] = mf.div_en ? qv[c] : undiv[c];
      if (mf.div_en && qovf[c]) ovf_next = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv[DS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x    <= fin[0];
      out_y    <= fin[1];
      out_z    <= fin[2];
      out_w    <= mf.w;
      w_zero   <= mf.wz;
      overflow <= ovf_next;
    end
  end

  // a flagged zero w must come with a zero w on the output
  a_wzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_zero |-> out_w == '0)
    else $error("w_zero set with nonzero out_w");

  // input side follows the output register's state
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output stall");

  // a held result keeps its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_w))
    else $error("stalled result changed");

endmodule
